FILE: src/mbetc_pkg.sv
// Shared types and constants for the escape-time color block.
// Used by the point queue, the iteration core, the color fold unit and the top level.
`default_nettype none

package mbetc_pkg;

  localparam int DATA_W          = 32;
  localparam int ITER_W          = 16;
  localparam int COLOR_W         = 16;
  localparam int NUM_COLORS_W    = 9;
  localparam int MASK_W          = 8;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;
  localparam int FRAC_BITS_DEF   = 28;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Palettes smaller than this fold by masking instead of by modulus.
  localparam int SMALL_PALETTE = 16;

  localparam logic [ITER_W-1:0]       ITER_LIMIT_RST = 16'd255;
  localparam logic [COLOR_W-1:0]      INSIDE_RST     = 16'd0;
  localparam logic [NUM_COLORS_W-1:0] NUM_COLORS_RST = 9'd256;
  localparam logic [MASK_W-1:0]       COLOR_MASK_RST = 8'd255;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } point_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] start_real;
    logic signed [DATA_W-1:0] start_imag;
    logic [ITER_W-1:0]        iter_limit;
    logic [COLOR_W-1:0]       inside_color;
  } core_cfg_t;

  typedef struct packed {
    logic [NUM_COLORS_W-1:0] num_colors;
    logic [MASK_W-1:0]       color_mask;
  } fold_cfg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_REAL   = 3'd0,
    CFG_START_IMAG   = 3'd1,
    CFG_ITER_LIMIT   = 3'd2,
    CFG_INSIDE_COLOR = 3'd3,
    CFG_NUM_COLORS   = 3'd4,
    CFG_COLOR_MASK   = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_MUL,
    CORE_UPD,
    CORE_DONE
  } core_state_t;

  typedef enum logic [1:0] {
    FOLD_IDLE,
    FOLD_DIV,
    FOLD_OUT
  } fold_state_t;

endpackage

`default_nettype wire

FILE: src/mandelbrot_escape_time_color.sv
// Top level of the escape-time color block: configuration registers, point
// queue, iteration core and color fold unit. Depends on mbetc_pkg and the mbetc_* modules.
`default_nettype none

// Each point c is iterated as z = z*z + c from the configured start value until
// |z|^2 reaches 4, a value saturates, or the iteration limit is reached; the
// count (or inside_color at the limit) is then folded into the palette. The
// iteration core uses a multiply state for the three 32x32 products and an
// update state for the update and escape test in each iteration. The magnitude
// of a new z is tested in the update state of the following iteration, so a
// point that escapes on |z|^2 runs a further multiply and update pass before
// it leaves the core, which a point that saturates or runs into the limit
// (255 by default) does not. The fold unit runs after the core, using a
// bit-serial remainder for the modulus case, and holds the result in its output
// register while the core already works on the next point; a small queue in
// front accepts points while the core is busy. Configuration may only be
// written while no point is in flight.
module mandelbrot_escape_time_color #(
  parameter int FRAC_BITS   = mbetc_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = mbetc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   cfg_write_en,
  input  wire [mbetc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [mbetc_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire signed [mbetc_pkg::DATA_W-1:0]    point_real,
  input  wire signed [mbetc_pkg::DATA_W-1:0]    point_imag,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [mbetc_pkg::COLOR_W-1:0]         pixel_color
);
  import mbetc_pkg::*;

  logic signed [DATA_W-1:0] start_real;
  logic signed [DATA_W-1:0] start_imag;
  logic [ITER_W-1:0]        iter_limit;
  logic [COLOR_W-1:0]       inside_color;
  logic [NUM_COLORS_W-1:0]  num_colors;
  logic [MASK_W-1:0]        color_mask;

  core_cfg_t          core_cfg;
  fold_cfg_t          fold_cfg;
  point_t             in_point;
  point_t             q_point;
  logic               q_valid;
  logic               core_ready;
  logic               core_valid;
  logic               fold_ready;
  logic [COLOR_W-1:0] core_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_real   <= '0;
      start_imag   <= '0;
      iter_limit   <= ITER_LIMIT_RST;
      inside_color <= INSIDE_RST;
      num_colors   <= NUM_COLORS_RST;
      color_mask   <= COLOR_MASK_RST;
    end else if (cfg_write_en) begin
      case (cfg_index_t'(cfg_index))
        CFG_START_REAL:   start_real   <= cfg_data[DATA_W-1:0];
        CFG_START_IMAG:   start_imag   <= cfg_data[DATA_W-1:0];
        CFG_ITER_LIMIT:   iter_limit   <= cfg_data[ITER_W-1:0];
        CFG_INSIDE_COLOR: inside_color <= cfg_data[COLOR_W-1:0];
        CFG_NUM_COLORS:   num_colors   <= cfg_data[NUM_COLORS_W-1:0];
        CFG_COLOR_MASK:   color_mask   <= cfg_data[MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign core_cfg = '{start_real: start_real, start_imag: start_imag,
                      iter_limit: iter_limit, inside_color: inside_color};
  assign fold_cfg = '{num_colors: num_colors, color_mask: color_mask};
  assign in_point = '{re: point_real, im: point_imag};

  mbetc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_point  (in_point),
    .out_valid (q_valid),
    .out_ready (core_ready),
    .out_point (q_point)
  );

  mbetc_core #(
    .FRAC_BITS(FRAC_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (core_cfg),
    .in_valid  (q_valid),
    .in_ready  (core_ready),
    .point     (q_point),
    .res_valid (core_valid),
    .res_ready (fold_ready),
    .res_color (core_color)
  );

  mbetc_fold u_fold (
    .clk       (clk),
    .rst       (rst),
    .cfg       (fold_cfg),
    .in_valid  (core_valid),
    .in_ready  (fold_ready),
    .in_color  (core_color),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_color (pixel_color)
  );

  // A full queue must have something to offer the core.
  assert property (@(posedge clk) disable iff (rst) !in_ready |-> q_valid)
    else $error("point queue reports full while empty");

  // Once the core takes a point it is busy for at least the next cycle.
  assert property (@(posedge clk) disable iff (rst) (q_valid && core_ready) |=> !core_ready)
    else $error("iteration core ready right after taking a point");

  // A raw color is either the inside color or a count below the limit.
  assert property (@(posedge clk) disable iff (rst)
    core_valid |-> ((core_color == inside_color) || (core_color < COLOR_W'(iter_limit))))
    else $error("iteration core produced a count beyond the limit");

endmodule

`default_nettype wire

FILE: src/mbetc_queue.sv
// Small point queue between the input port and the iteration core.
// Depends on mbetc_pkg for the point type.
`default_nettype none

module mbetc_queue #(
  parameter int DEPTH = mbetc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  mbetc_pkg::point_t    in_point,
  output logic                 out_valid,
  input  wire                  out_ready,
  output mbetc_pkg::point_t    out_point
);
  import mbetc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  point_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_point = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_point;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/mbetc_core.sv
// Escape-time iteration core: z = z*z + c in signed fixed point, each iteration
// in a multiply stage followed by an update stage. Depends on mbetc_pkg.
`default_nettype none

module mbetc_core #(
  parameter int FRAC_BITS = mbetc_pkg::FRAC_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  mbetc_pkg::core_cfg_t                cfg,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  mbetc_pkg::point_t                   point,
  output logic                                res_valid,
  input  wire                                 res_ready,
  output logic [mbetc_pkg::COLOR_W-1:0]       res_color
);
  import mbetc_pkg::*;

  localparam int PROD_W = 2 * DATA_W;
  localparam logic [PROD_W-1:0] LIMIT = PROD_W'(4) << FRAC_BITS;

  core_state_t state;
  core_state_t state_next;

  logic signed [DATA_W-1:0] cr;
  logic signed [DATA_W-1:0] ci;
  logic signed [DATA_W-1:0] zr;
  logic signed [DATA_W-1:0] zi;
  logic [ITER_W-1:0]        iter;
  logic                     first;

  logic signed [PROD_W-1:0] p_rr;
  logic signed [PROD_W-1:0] p_ii;
  logic signed [PROD_W-1:0] p_ri;

  logic [PROD_W-1:0]        mag;
  logic                     esc;
  logic signed [PROD_W-1:0] diff;
  logic signed [PROD_W-1:0] nr_w;
  logic signed [PROD_W-1:0] ni_w;
  logic                     nr_ovf;
  logic                     ni_ovf;
  logic [DATA_W-1:0]        nr_sat;
  logic [DATA_W-1:0]        ni_sat;
  logic [ITER_W-1:0]        iter_inc;
  logic                     stop_now;
  logic                     stop_after;

  function automatic logic [COLOR_W-1:0] pick_color(input logic [ITER_W-1:0] it,
                                                    input core_cfg_t c);
    pick_color = (it >= c.iter_limit) ? c.inside_color : COLOR_W'(it);
  endfunction

  // The products in p_rr and p_ii belong to the current z, so their sum is
  // the magnitude test for the result of the previous iteration.
  assign mag = $unsigned(p_rr) + $unsigned(p_ii);
  assign esc = (mag >> FRAC_BITS) >= LIMIT;

  assign diff = p_rr - p_ii;
  assign nr_w = (diff >>> FRAC_BITS) + $signed({{DATA_W{cr[DATA_W-1]}}, cr});
  assign ni_w = (p_ri >>> (FRAC_BITS - 1)) + $signed({{DATA_W{ci[DATA_W-1]}}, ci});

  // A value fits in the word when its top bits all copy the sign bit.
  assign nr_ovf = !((&nr_w[PROD_W-1:DATA_W-1]) || !(|nr_w[PROD_W-1:DATA_W-1]));
  assign ni_ovf = !((&ni_w[PROD_W-1:DATA_W-1]) || !(|ni_w[PROD_W-1:DATA_W-1]));
  assign nr_sat = nr_ovf ? {nr_w[PROD_W-1], {(DATA_W-1){!nr_w[PROD_W-1]}}}
                         : nr_w[DATA_W-1:0];
  assign ni_sat = ni_ovf ? {ni_w[PROD_W-1], {(DATA_W-1){!ni_w[PROD_W-1]}}}
                         : ni_w[DATA_W-1:0];

  assign iter_inc   = iter + 1'b1;
  assign stop_now   = (!first && esc) || (iter >= cfg.iter_limit);
  assign stop_after = nr_ovf || ni_ovf || (iter_inc >= cfg.iter_limit);

  always_comb begin
    state_next = state;
    case (state)
      CORE_IDLE: begin
        if (in_valid) begin
          state_next = CORE_MUL;
        end
      end
      CORE_MUL: begin
        state_next = CORE_UPD;
      end
      CORE_UPD: begin
        if (stop_now || stop_after) begin
          state_next = CORE_DONE;
        end else begin
          state_next = CORE_MUL;
        end
      end
      CORE_DONE: begin
        if (res_ready) begin
          state_next = CORE_IDLE;
        end
      end
      default: begin
        state_next = CORE_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    case (state)
      CORE_IDLE: in_ready  = 1'b1;
      CORE_DONE: res_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CORE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      CORE_IDLE: begin
        if (in_valid) begin
          cr    <= point.re;
          ci    <= point.im;
          zr    <= cfg.start_real;
          zi    <= cfg.start_imag;
          iter  <= '0;
          first <= 1'b1;
        end
      end
      CORE_MUL: begin
        p_rr <= zr * zr;
        p_ii <= zi * zi;
        p_ri <= zr * zi;
      end
      CORE_UPD: begin
        if (stop_now) begin
          res_color <= pick_color(iter, cfg);
        end else begin
          zr    <= nr_sat;
          zi    <= ni_sat;
          iter  <= iter_inc;
          first <= 1'b0;
          res_color <= pick_color(iter_inc, cfg);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: src/mbetc_fold.sv
// Color fold unit with output register: masks or reduces a raw color beyond
// the palette, using a bit-serial remainder, else passes it on. Depends on mbetc_pkg.
`default_nettype none

module mbetc_fold (
  input  wire                             clk,
  input  wire                             rst,
  input  mbetc_pkg::fold_cfg_t            cfg,
  input  wire                             in_valid,
  output logic                            in_ready,
  input  wire [mbetc_pkg::COLOR_W-1:0]    in_color,
  output logic                            out_valid,
  input  wire                             out_ready,
  output logic [mbetc_pkg::COLOR_W-1:0]   out_color
);
  import mbetc_pkg::*;

  localparam int CNT_W = $clog2(COLOR_W);

  fold_state_t state;
  fold_state_t state_next;

  logic [COLOR_W-1:0] dividend;
  logic [MASK_W-1:0]  rem;
  logic [CNT_W-1:0]   bit_cnt;
  logic [COLOR_W-1:0] result;

  logic               beyond;
  logic               small_pal;
  logic               need_div;
  logic [MASK_W:0]    trial;
  logic [MASK_W:0]    trial_sub;
  logic [MASK_W-1:0]  rem_step;

  assign beyond    = in_color >= COLOR_W'(cfg.num_colors);
  assign small_pal = cfg.num_colors < NUM_COLORS_W'(SMALL_PALETTE);
  assign need_div  = beyond && !small_pal && (cfg.color_mask != '0) && (in_color != '0);

  // One restoring step of (color - 1) mod color_mask per cycle, MSB first.
  assign trial     = {rem, dividend[COLOR_W-1]};
  assign trial_sub = trial - {1'b0, cfg.color_mask};
  assign rem_step  = (trial >= {1'b0, cfg.color_mask}) ? trial_sub[MASK_W-1:0]
                                                      : trial[MASK_W-1:0];

  assign out_color = result;

  always_comb begin
    state_next = state;
    case (state)
      FOLD_IDLE: begin
        if (in_valid) begin
          state_next = need_div ? FOLD_DIV : FOLD_OUT;
        end
      end
      FOLD_DIV: begin
        if (bit_cnt == '0) begin
          state_next = FOLD_OUT;
        end
      end
      FOLD_OUT: begin
        if (out_ready) begin
          state_next = FOLD_IDLE;
        end
      end
      default: begin
        state_next = FOLD_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      FOLD_IDLE: in_ready  = 1'b1;
      FOLD_OUT:  out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FOLD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      FOLD_IDLE: begin
        if (in_valid) begin
          dividend <= in_color - 1'b1;
          rem      <= '0;
          bit_cnt  <= CNT_W'(COLOR_W - 1);
          if (beyond && small_pal) begin
            result <= in_color & COLOR_W'(cfg.color_mask);
          end else begin
            result <= in_color;
          end
        end
      end
      FOLD_DIV: begin
        rem      <= rem_step;
        dividend <= dividend << 1;
        bit_cnt  <= bit_cnt - 1'b1;
        if (bit_cnt == '0) begin
          result <= COLOR_W'(rem_step) + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: bench/mandelbrot_escape_time_color_tb.sv
// Self-checking bench for the escape-time color block: directed plan, then random points.
// Colors are predicted in the bench from the register settings and checked in order.
// Depends on mbetc_pkg and the mandelbrot_escape_time_color top level.
module mandelbrot_escape_time_color_tb;
  import mbetc_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS = 1600;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int HOLD_OFF_AT = 150;
  localparam int HOLD_OFF_CYCLES = 3000;
  localparam longint SAT_HI = (longint'(1) <<< 31) - 1;
  localparam longint SAT_LO = -(longint'(1) <<< 31);
  localparam bit [63:0] ESC_BOUND = 64'd4 << FRAC;

  typedef enum logic {ROW_WRITE, ROW_POINT} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    cfg_index_t         reg_sel;
    logic [31:0]        value;
    logic [DATA_W-1:0]  re;
    logic [DATA_W-1:0]  im;
    logic               typed;
    logic [COLOR_W-1:0] color;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  cfg_index_t cfg_index = CFG_START_REAL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_W-1:0] point_real = '0;
  logic signed [DATA_W-1:0] point_imag = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COLOR_W-1:0] pixel_color;

  // Bench copy of the register file.
  logic signed [DATA_W-1:0] z0_real = '0;
  logic signed [DATA_W-1:0] z0_imag = '0;
  logic [ITER_W-1:0] iter_limit = ITER_LIMIT_RST;
  logic [COLOR_W-1:0] inside_shade = INSIDE_RST;
  logic [NUM_COLORS_W-1:0] pal_size = NUM_COLORS_RST;
  logic [MASK_W-1:0] pal_mask = COLOR_MASK_RST;

  logic [COLOR_W-1:0] pending_colors [$];
  int mismatches = 0;
  int colors_seen = 0;
  int random_sent = 0;
  int burst_left = 0;
  bit held_off = 1'b0;
  bit steady = 1'b0;

  // A point is typed with its color where the answer is plain from the rules.
  plan_row_t plan [46] = '{
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 16'd1},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h8000_0000, 32'h8000_0000, 1'b1, 16'd1},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h2000_0000, 32'h0000_0000, 1'b1, 16'd1},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'hE000_0000, 32'h0000_0000, 1'b1, 16'd1},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h1000_0000, 32'h0000_0000, 1'b0, 16'd0},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'hF400_0000, 32'h0199_9999, 1'b0, 16'd0},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_ITER_LIMIT, 32'h0, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_INSIDE_COLOR, 32'd9, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 16'd9},
    '{ROW_WRITE, CFG_ITER_LIMIT, 32'd1, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h2800_0000, 32'h0000_0000, 1'b1, 16'd9},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'd9},
    '{ROW_WRITE, CFG_START_REAL, 32'h3000_0000, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_START_IMAG, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_ITER_LIMIT, 32'd20, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_INSIDE_COLOR, 32'hFFFF, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_START_REAL, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_START_IMAG, 32'h7FFF_FFFF, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_NUM_COLORS, 32'd2, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_COLOR_MASK, 32'd1, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_START_REAL, 32'h0, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_START_IMAG, 32'h0, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_ITER_LIMIT, 32'hFFFF, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h1000_0000, 32'h0000_0000, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_NUM_COLORS, 32'd16, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_COLOR_MASK, 32'd0, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_ITER_LIMIT, 32'd40, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_INSIDE_COLOR, 32'h8000, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'h8000},
    '{ROW_WRITE, CFG_NUM_COLORS, 32'd256, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_COLOR_MASK, 32'd255, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_ITER_LIMIT, 32'd300, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_INSIDE_COLOR, 32'hFFFF, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'hF000_0000, 32'h0000_0000, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_NUM_COLORS, 32'd15, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_COLOR_MASK, 32'h0A, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_WRITE, CFG_ITER_LIMIT, 32'd30, 32'h0, 32'h0, 1'b0, 16'd0},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h1000_0000, 32'h0000_0000, 1'b1, 16'd2},
    '{ROW_POINT, CFG_START_REAL, 32'h0, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'h000A}
  };

  mandelbrot_escape_time_color u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .point_real   (point_real),
    .point_imag   (point_imag),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_color  (pixel_color)
  );

  always #6 clk = ~clk;

  // Escape count of one point under the current settings, folded into the palette.
  function automatic logic [COLOR_W-1:0] escape_color(input logic signed [DATA_W-1:0] c_re,
                                                      input logic signed [DATA_W-1:0] c_im);
    longint zr, zi, rr, ii, ri, nr, ni;
    bit [63:0] mag;
    bit ovf;
    bit gone;
    int unsigned n;
    int unsigned tally;
    zr = z0_real;
    zi = z0_imag;
    n = 0;
    gone = 1'b0;
    while (!gone && n < iter_limit) begin
      rr = zr * zr;
      ii = zi * zi;
      ri = zr * zi;
      nr = ((rr - ii) >>> FRAC) + longint'(c_re);
      ni = (ri >>> (FRAC - 1)) + longint'(c_im);
      ovf = 1'b0;
      if (nr > SAT_HI) begin
        nr = SAT_HI;
        ovf = 1'b1;
      end else if (nr < SAT_LO) begin
        nr = SAT_LO;
        ovf = 1'b1;
      end
      if (ni > SAT_HI) begin
        ni = SAT_HI;
        ovf = 1'b1;
      end else if (ni < SAT_LO) begin
        ni = SAT_LO;
        ovf = 1'b1;
      end
      n++;
      zr = nr;
      zi = ni;
      // The two squares are at most 2^62 each, so the sum fits as unsigned.
      mag = zr * zr + zi * zi;
      if (ovf || (mag >> FRAC) >= ESC_BOUND) gone = 1'b1;
    end
    tally = (n >= iter_limit) ? inside_shade : n;
    if (tally >= pal_size) begin
      if (pal_size < SMALL_PALETTE) tally = tally & pal_mask;
      else if (pal_mask != 0 && tally != 0) tally = (tally - 1) % pal_mask + 1;
    end
    return tally[COLOR_W-1:0];
  endfunction

  // Back-to-back when steady; otherwise mostly back-to-back, sometimes a short gap, rarely a long pause.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(30, 120);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH after %0d colors: %s", colors_seen, msg);
    mismatches++;
  endtask

  task automatic take_color(input logic [COLOR_W-1:0] got);
    logic [COLOR_W-1:0] want;
    colors_seen++;
    if (pending_colors.size() == 0) begin
      report_mismatch($sformatf("pixel_color %0d with no point outstanding", got));
    end else begin
      want = pending_colors.pop_front();
      if (got !== want)
        report_mismatch($sformatf("pixel_color got %0d want %0d", got, want));
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] v);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    case (idx)
      CFG_START_REAL:   z0_real = v;
      CFG_START_IMAG:   z0_imag = v;
      CFG_ITER_LIMIT:   iter_limit = v[ITER_W-1:0];
      CFG_INSIDE_COLOR: inside_shade = v[COLOR_W-1:0];
      CFG_NUM_COLORS:   pal_size = v[NUM_COLORS_W-1:0];
      CFG_COLOR_MASK:   pal_mask = v[MASK_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Holds a point until its transfer, then books the color it must produce.
  task automatic send_point(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im,
                            input logic typed, input logic [COLOR_W-1:0] color);
    int g;
    in_valid <= 1'b1;
    point_real <= re;
    point_imag <= im;
    do @(posedge clk); while (!in_ready);
    if (typed) pending_colors.push_back(color);
    else pending_colors.push_back(escape_color(re, im));
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_colors.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    int pick;
    int burst;
    logic [31:0] re;
    logic [31:0] im;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan[k].reg_sel, plan[k].value);
      end else begin
        send_point(plan[k].re, plan[k].im, plan[k].typed, plan[k].color);
      end
    end
    while (random_sent < RANDOM_ITEMS) begin
      wait_idle();
      steady = ($urandom_range(0, 3) == 0);
      // Keep the limit low most of the time so the run stays short.
      pick = $urandom_range(0, 15);
      if (pick == 0) write_reg(CFG_ITER_LIMIT, 0);
      else if (pick < 12) write_reg(CFG_ITER_LIMIT, $urandom_range(1, 40));
      else if (pick < 15) write_reg(CFG_ITER_LIMIT, $urandom_range(41, 300));
      else write_reg(CFG_ITER_LIMIT, 255);
      pick = $urandom_range(0, 3);
      if (pick < 2) begin
        re = '0;
        im = '0;
      end else if (pick == 2) begin
        re = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
        im = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
      end else begin
        re = $urandom;
        im = $urandom;
      end
      write_reg(CFG_START_REAL, re);
      write_reg(CFG_START_IMAG, im);
      write_reg(CFG_INSIDE_COLOR, $urandom_range(0, 1) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 300));
      pick = $urandom_range(0, 4);
      case (pick)
        0: write_reg(CFG_NUM_COLORS, 2);
        1: write_reg(CFG_NUM_COLORS, $urandom_range(2, 15));
        2: write_reg(CFG_NUM_COLORS, 16);
        3: write_reg(CFG_NUM_COLORS, $urandom_range(17, 256));
        default: write_reg(CFG_NUM_COLORS, 256);
      endcase
      write_reg(CFG_COLOR_MASK, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255));
      burst = $urandom_range(10, 60);
      burst_left = burst;
      repeat (burst) begin
        // Most points fall around the set, where iteration counts vary the most.
        if ($urandom_range(0, 9) < 7) begin
          re = $urandom_range(0, 32'h3000_0000) - 32'h2400_0000;
          im = $urandom_range(0, 32'h2800_0000) - 32'h1400_0000;
        end else begin
          re = $urandom;
          im = $urandom;
        end
        send_point(re, im, 1'b0, '0);
        random_sent++;
        burst_left--;
      end
    end
    wait_idle();
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : result_side
    int stall_left;
    stall_left = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (out_ready && out_valid) begin
        take_color(pixel_color);
        // One long hold-off, taken while a burst still has points to send, lets
        // the queue and the core back up into the input.
        if (!held_off && colors_seen >= HOLD_OFF_AT && burst_left >= 8) begin
          stall_left = HOLD_OFF_CYCLES;
          held_off = 1'b1;
        end else begin
          stall_left = gap_len();
        end
      end else if (out_ready && $urandom_range(0, 11) == 0) begin
        stall_left = gap_len();
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

endmodule
